@@ rtl/core/alt_landmark_lower_bound_macros.svh @@
// Assertion macros shared by the landmark lower-bound RTL.
`ifndef ALT_LANDMARK_LOWER_BOUND_MACROS_SVH
`define ALT_LANDMARK_LOWER_BOUND_MACROS_SVH

// Both macros sample on i_clk and are off while i_rst_n is low.
// Same-cycle implication.
`define ALB_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ALB_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/alb_pkg.sv @@
// Package: sizes, codes, state type and interface structs of the lower-bound engine.
`timescale 1ns / 1ps
package alb_pkg;

    localparam int VERTEX_COUNT = 1024;
    localparam int LANDMARK_MAX = 16;
    localparam int GROUP_MAX    = 256;
    localparam int DIST_BITS    = 16;

    localparam int VTX_BITS   = $clog2(VERTEX_COUNT);
    localparam int LM_BITS    = $clog2(LANDMARK_MAX);
    localparam int POS_BITS   = $clog2(GROUP_MAX);
    localparam int VADDR_BITS = VTX_BITS + LM_BITS;
    localparam int GADDR_BITS = LM_BITS + POS_BITS;

    // Config register widths.
    localparam int LMC_BITS = 5;
    localparam int GSZ_BITS = 9;

    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;

    // Register select bit of paddr (word index).
    localparam logic REG_LANDMARK_COUNT = 1'b0;
    localparam logic REG_GROUP_SIZE     = 1'b1;

    typedef enum logic [1:0] {
        MODE_WR_VERTEX = 2'd0,
        MODE_WR_GROUP  = 2'd1,
        MODE_PAIR      = 2'd2,
        MODE_GROUP     = 2'd3
    } t_mode;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PA,    // read dist(a, l)
        S_PB,    // read dist(b, l)
        S_PD,    // pair gap
        S_GA,    // read dist(a, l) and last list entry
        S_GB,    // read first list entry
        S_GC,    // end checks
        S_GM,    // search step: issue mid read or finish
        S_GW,    // search step: narrow bounds, or finish on an exact hit
        S_DONE
    } t_state;

    typedef struct packed {
        logic [LMC_BITS-1:0] landmark_count;
        logic [GSZ_BITS-1:0] group_size;
    } t_cfg;

    typedef struct packed {
        logic                  we;
        logic                  re;
        logic [VADDR_BITS-1:0] addr;
        logic [DIST_BITS-1:0]  wdata;
    } t_vreq;

    typedef struct packed {
        logic                  we;
        logic                  re;
        logic [GADDR_BITS-1:0] addr;
        logic [DIST_BITS-1:0]  wdata;
    } t_greq;

endpackage

@@ rtl/core/alb_ram.sv @@
// Single-port synchronous RAM, registered read data.
`timescale 1ns / 1ps
module alb_ram #(
    parameter int ADDR_BITS = alb_pkg::VADDR_BITS,
    parameter int DATA_BITS = alb_pkg::DIST_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic                 i_re,
    input  logic [ADDR_BITS-1:0] i_addr,
    input  logic [DATA_BITS-1:0] i_wdata,
    output logic [DATA_BITS-1:0] o_rdata
);

    logic [DATA_BITS-1:0] r_mem [(2**ADDR_BITS)];
    logic [DATA_BITS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/alb_regs.sv @@
// APB configuration registers: landmark count and group size.
`timescale 1ns / 1ps
module alb_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [alb_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [alb_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [alb_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                               pready,
    output alb_pkg::t_cfg                      o_cfg
);
    import alb_pkg::*;

    logic [LMC_BITS-1:0] r_landmark_count;
    logic [GSZ_BITS-1:0] r_group_size;
    logic                wr;

    assign pready = 1'b1;
    assign wr     = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_landmark_count <= LMC_BITS'(1);
            r_group_size     <= GSZ_BITS'(1);
        end else if (wr) begin
            case (paddr[2])
                REG_LANDMARK_COUNT: r_landmark_count <= pwdata[LMC_BITS-1:0];
                REG_GROUP_SIZE:     r_group_size     <= pwdata[GSZ_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_LANDMARK_COUNT:
                prdata = {{(APB_DATA_BITS-LMC_BITS){1'b0}}, r_landmark_count};
            REG_GROUP_SIZE:
                prdata = {{(APB_DATA_BITS-GSZ_BITS){1'b0}}, r_group_size};
            default:
                prdata = '0;
        endcase
    end

    assign o_cfg.landmark_count = r_landmark_count;
    assign o_cfg.group_size     = r_group_size;

endmodule

@@ rtl/core/alb_seq.sv @@
// Sequencer: writes, pair scan and per-landmark binary search over the two tables.
`timescale 1ns / 1ps
`include "alt_landmark_lower_bound_macros.svh"
module alb_seq (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  alb_pkg::t_cfg                  i_cfg,
    input  logic                           i_start,
    input  logic [1:0]                     i_mode,
    input  logic [alb_pkg::VTX_BITS-1:0]   i_vertex_a,
    input  logic [alb_pkg::VTX_BITS-1:0]   i_vertex_b,
    input  logic [alb_pkg::LM_BITS-1:0]    i_landmark,
    input  logic [alb_pkg::POS_BITS-1:0]   i_position,
    input  logic [alb_pkg::DIST_BITS-1:0]  i_value,
    input  logic [alb_pkg::DIST_BITS-1:0]  i_vdata,
    input  logic [alb_pkg::DIST_BITS-1:0]  i_gdata,
    output alb_pkg::t_vreq                 o_vreq,
    output alb_pkg::t_greq                 o_greq,
    output logic                           o_busy,
    output logic                           o_valid,
    output logic [alb_pkg::DIST_BITS-1:0]  o_estimate
);
    import alb_pkg::*;

    t_state               r_state, n_state;
    logic [VTX_BITS-1:0]  r_va, n_va;
    logic [VTX_BITS-1:0]  r_vb, n_vb;
    logic [LM_BITS-1:0]   r_i, n_i;
    logic [DIST_BITS-1:0] r_best, n_best;
    logic [DIST_BITS-1:0] r_d, n_d;
    logic [DIST_BITS-1:0] r_elo, n_elo;
    logic [DIST_BITS-1:0] r_ehi, n_ehi;
    logic [POS_BITS-1:0]  r_lo, n_lo;
    logic [POS_BITS-1:0]  r_hi, n_hi;
    logic [POS_BITS-1:0]  r_mid, n_mid;

    logic                 accept;
    logic [LMC_BITS-1:0]  lm_active;
    logic [LM_BITS-1:0]   lm_last;
    logic [POS_BITS-1:0]  g_last;
    logic [POS_BITS:0]    lo_hi_sum;
    logic [POS_BITS-1:0]  mid;
    logic                 span_open;
    logic [DIST_BITS-1:0] gap;
    logic                 gap_upd;
    logic                 step_next;
    logic [DIST_BITS-1:0] gap_lo, gap_hi;

    assign accept = i_start & (r_state == S_IDLE);

    // Active landmark count saturates at the table size; group size 0 acts as 1.
    assign lm_active = (i_cfg.landmark_count > LMC_BITS'(LANDMARK_MAX))
                     ? LMC_BITS'(LANDMARK_MAX) : i_cfg.landmark_count;
    assign lm_last   = LM_BITS'(lm_active - LMC_BITS'(1));

    always_comb begin
        if (i_cfg.group_size == '0) begin
            g_last = '0;
        end else if (i_cfg.group_size > GSZ_BITS'(GROUP_MAX)) begin
            g_last = POS_BITS'(GROUP_MAX - 1);
        end else begin
            g_last = POS_BITS'(i_cfg.group_size - GSZ_BITS'(1));
        end
    end

    assign lo_hi_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid       = lo_hi_sum[POS_BITS:1];
    assign span_open = (r_hi - r_lo) > POS_BITS'(1);
    assign gap_lo    = r_d - r_elo;
    assign gap_hi    = r_ehi - r_d;

    // Next state and datapath registers.
    always_comb begin
        n_state   = r_state;
        n_va      = r_va;
        n_vb      = r_vb;
        n_i       = r_i;
        n_best    = r_best;
        n_d       = r_d;
        n_elo     = r_elo;
        n_ehi     = r_ehi;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_mid     = r_mid;
        gap       = '0;
        gap_upd   = 1'b0;
        step_next = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (accept && ((i_mode == MODE_PAIR) || (i_mode == MODE_GROUP))) begin
                    n_va   = i_vertex_a;
                    n_vb   = i_vertex_b;
                    n_i    = '0;
                    n_best = '0;
                    if (lm_active == '0) begin
                        n_state = S_DONE;
                    end else if (i_mode == MODE_PAIR) begin
                        n_state = S_PA;
                    end else begin
                        n_state = S_GA;
                    end
                end
            end
            S_PA: begin
                n_state = S_PB;
            end
            S_PB: begin
                n_d     = i_vdata;
                n_state = S_PD;
            end
            S_PD: begin
                gap       = (r_d >= i_vdata) ? (r_d - i_vdata) : (i_vdata - r_d);
                gap_upd   = 1'b1;
                step_next = 1'b1;
            end
            S_GA: begin
                n_state = S_GB;
            end
            S_GB: begin
                n_d     = i_vdata;
                n_ehi   = i_gdata;
                n_state = S_GC;
            end
            S_GC: begin
                if (r_d >= r_ehi) begin
                    gap       = r_d - r_ehi;
                    gap_upd   = 1'b1;
                    step_next = 1'b1;
                end else if (r_d <= i_gdata) begin
                    gap       = i_gdata - r_d;
                    gap_upd   = 1'b1;
                    step_next = 1'b1;
                end else begin
                    n_elo   = i_gdata;
                    n_lo    = '0;
                    n_hi    = g_last;
                    n_state = S_GM;
                end
            end
            S_GM: begin
                if (span_open) begin
                    n_mid   = mid;
                    n_state = S_GW;
                end else begin
                    gap       = (gap_lo < gap_hi) ? gap_lo : gap_hi;
                    gap_upd   = 1'b1;
                    step_next = 1'b1;
                end
            end
            S_GW: begin
                if (i_gdata == r_d) begin
                    // exact hit: gap zero never raises the maximum
                    step_next = 1'b1;
                end else if (i_gdata < r_d) begin
                    n_lo    = r_mid;
                    n_elo   = i_gdata;
                    n_state = S_GM;
                end else begin
                    n_hi    = r_mid;
                    n_ehi   = i_gdata;
                    n_state = S_GM;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (gap_upd && (gap > r_best)) begin
            n_best = gap;
        end

        if (step_next) begin
            if (r_i == lm_last) begin
                n_state = S_DONE;
            end else begin
                n_i     = r_i + LM_BITS'(1);
                n_state = (r_state == S_PD) ? S_PA : S_GA;
            end
        end
    end

    // Memory requests and handshake outputs.
    always_comb begin
        o_vreq       = '0;
        o_greq       = '0;
        o_vreq.wdata = i_value;
        o_greq.wdata = i_value;
        o_vreq.addr  = {i_vertex_a, i_landmark};
        o_greq.addr  = {i_landmark, i_position};

        case (r_state)
            S_IDLE: begin
                o_vreq.we = accept && (i_mode == MODE_WR_VERTEX);
                o_greq.we = accept && (i_mode == MODE_WR_GROUP);
            end
            S_PA: begin
                o_vreq.re   = 1'b1;
                o_vreq.addr = {r_va, r_i};
            end
            S_PB: begin
                o_vreq.re   = 1'b1;
                o_vreq.addr = {r_vb, r_i};
            end
            S_GA: begin
                o_vreq.re   = 1'b1;
                o_vreq.addr = {r_va, r_i};
                o_greq.re   = 1'b1;
                o_greq.addr = {r_i, g_last};
            end
            S_GB: begin
                o_greq.re   = 1'b1;
                o_greq.addr = {r_i, POS_BITS'(0)};
            end
            S_GM: begin
                o_greq.re   = span_open;
                o_greq.addr = {r_i, mid};
            end
            default: ;
        endcase

        o_busy     = (r_state != S_IDLE);
        o_valid    = (r_state == S_DONE);
        o_estimate = r_best;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_va   <= n_va;
        r_vb   <= n_vb;
        r_i    <= n_i;
        r_best <= n_best;
        r_d    <= n_d;
        r_elo  <= n_elo;
        r_ehi  <= n_ehi;
        r_lo   <= n_lo;
        r_hi   <= n_hi;
        r_mid  <= n_mid;
    end

    `ALB_ASSERT_NXT(a_valid_pulse, o_valid, !o_valid, "result strobe longer than one cycle")
    `ALB_ASSERT_IMP(a_wr_idle, o_vreq.we || o_greq.we, r_state == S_IDLE, "table write while busy")
    `ALB_ASSERT_NXT(a_query_busy, accept && i_mode[1], o_busy, "query accepted without going busy")
    `ALB_ASSERT_NXT(a_write_fast, accept && !i_mode[1], !o_busy, "table write held the engine")
    `ALB_ASSERT_IMP(a_search_span, r_state == S_GM, r_lo < r_hi, "search bounds crossed")

endmodule

@@ rtl/core/alt_landmark_lower_bound.sv @@
// Top level of the landmark (ALT) distance lower-bound engine.
//
//  channel   | ports                                         | transfer when
//  ----------+-----------------------------------------------+--------------------------------
//  item in   | start, busy, i_mode .. i_value                | start high, busy low
//  result    | o_valid, o_estimate                           | o_valid high (one cycle)
//  config    | psel, penable, pwrite, paddr, pwdata, prdata  | psel, penable, pwrite, pready
//
// Table writes (modes 0, 1) take effect at the accept edge; busy never rises.
// Pair estimate: per active landmark PA and PB read dist(a, l) and dist(b, l), PD takes the gap,
//   then the result strobe; with no active landmark only the strobe.
// Group estimate: per landmark, GA and GB read dist(a, l) and both list ends, GC checks
//   the ends, then each binary search step (at most 8 for a 256-entry list) runs GM
//   (mid read) and GW (narrow bounds); GC, GW or a final GM closes the landmark, and
//   the result strobe follows. The single read port of the group table splits the end reads.
// Reset (i_rst_n low, synchronous) returns to idle and sets landmark_count and
//   group_size to 1. The tables are not cleared; the user must write an entry before
//   it is read, which the block itself does not enforce.
// The result strobe lasts one cycle and cannot be stalled; busy stays high
//   through it.
`timescale 1ns / 1ps
module alt_landmark_lower_bound (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // item channel
    input  logic                               start,
    output logic                               busy,
    input  logic [1:0]                         i_mode,
    input  logic [alb_pkg::VTX_BITS-1:0]       i_vertex_a,
    input  logic [alb_pkg::VTX_BITS-1:0]       i_vertex_b,
    input  logic [alb_pkg::LM_BITS-1:0]        i_landmark,
    input  logic [alb_pkg::POS_BITS-1:0]       i_position,
    input  logic [alb_pkg::DIST_BITS-1:0]      i_value,
    // result channel
    output logic                               o_valid,
    output logic [alb_pkg::DIST_BITS-1:0]      o_estimate,
    // configuration
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [alb_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [alb_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [alb_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                               pready
);
    import alb_pkg::*;

    t_cfg                 cfg;
    t_vreq                vreq;
    t_greq                greq;
    logic [DIST_BITS-1:0] vdata;
    logic [DIST_BITS-1:0] gdata;

    alb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // vertex table: address {vertex, landmark}
    alb_ram #(
        .ADDR_BITS (VADDR_BITS),
        .DATA_BITS (DIST_BITS)
    ) u_vmem (
        .i_clk   (i_clk),
        .i_we    (vreq.we),
        .i_re    (vreq.re),
        .i_addr  (vreq.addr),
        .i_wdata (vreq.wdata),
        .o_rdata (vdata)
    );

    // group lists: address {landmark, position}
    alb_ram #(
        .ADDR_BITS (GADDR_BITS),
        .DATA_BITS (DIST_BITS)
    ) u_gmem (
        .i_clk   (i_clk),
        .i_we    (greq.we),
        .i_re    (greq.re),
        .i_addr  (greq.addr),
        .i_wdata (greq.wdata),
        .o_rdata (gdata)
    );

    alb_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_start    (start),
        .i_mode     (i_mode),
        .i_vertex_a (i_vertex_a),
        .i_vertex_b (i_vertex_b),
        .i_landmark (i_landmark),
        .i_position (i_position),
        .i_value    (i_value),
        .i_vdata    (vdata),
        .i_gdata    (gdata),
        .o_vreq     (vreq),
        .o_greq     (greq),
        .o_busy     (busy),
        .o_valid    (o_valid),
        .o_estimate (o_estimate)
    );

endmodule
